[rtl/core/twdf_pkg.sv]
`default_nettype none
package twdf_pkg;

  localparam int unsigned DEPTH_DEFAULT     = 16;
  localparam int unsigned KEY_WIDTH_DEFAULT = 32;
  localparam int unsigned KEY_PORT_W        = 32;
  localparam int unsigned TIME_W            = 32;
  localparam int unsigned LIMIT_W           = 32;

  localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = LIMIT_W'(25 * 1000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_AGE,
    ST_FINISH
  } twdf_state_t;

  typedef struct packed {
    logic accepted;
    logic removed;
    logic evicted_full;
  } twdf_result_t;

endpackage
`default_nettype wire

[rtl/core/twdf_if.sv]
`default_nettype none
interface twdf_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [twdf_pkg::TIME_W-1:0]        now_ms;
  logic [twdf_pkg::KEY_PORT_W-1:0]    station_key;
  logic [twdf_pkg::KEY_PORT_W-1:0]    payload_key;

  modport source (output valid, action, now_ms, station_key, payload_key, input ready);
  modport sink   (input valid, action, now_ms, station_key, payload_key, output ready);
endinterface

interface twdf_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic removed;
  logic evicted_full;

  modport source (output valid, accepted, removed, evicted_full, input ready);
  modport sink   (input valid, accepted, removed, evicted_full, output ready);
endinterface

interface twdf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [twdf_pkg::LIMIT_W-1:0]     age_limit_ms;

  modport source (output valid, age_limit_ms, input ready);
  modport sink   (input valid, age_limit_ms, output ready);
endinterface
`default_nettype wire

[rtl/core/time_window_duplicate_filter_core.sv]
// Check request: SCAN reads each stored entry of the entry RAM in turn, then DRAIN, then
// FINISH; a clean request reads the oldest entry in AGE, then FINISH; on an empty table
// either goes straight to FINISH. One request at a time: the next is taken in the cycle
// after the result enters the output register, while that result waits.
// Reset: table empty, oldest and tail pointers at zero, age limit 25000 ms, output empty.
// The entry RAM is not cleared; no entry is read before it is written.
`default_nettype none
module time_window_duplicate_filter_core #(
  parameter int unsigned DEPTH     = twdf_pkg::DEPTH_DEFAULT,
  parameter int unsigned KEY_WIDTH = twdf_pkg::KEY_WIDTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  twdf_in_if.sink       in_req,
  twdf_out_if.source    out_res,
  twdf_cfg_if.sink      cfg_wr
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned KW = (KEY_WIDTH < twdf_pkg::KEY_PORT_W) ? KEY_WIDTH
                                                                    : twdf_pkg::KEY_PORT_W;
  localparam int unsigned WORD_W = 2 * KW + twdf_pkg::TIME_W;

  logic [twdf_pkg::LIMIT_W-1:0] age_limit_r;
  logic                         out_valid_r;
  twdf_pkg::twdf_result_t       out_data_r;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [WORD_W-1:0]            mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [WORD_W-1:0]            mem_rdata;
  logic                         res_valid;
  twdf_pkg::twdf_result_t       res;
  logic                         res_free;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= twdf_pkg::AGE_LIMIT_RESET;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      age_limit_r <= cfg_wr.age_limit_ms;
    end
  end

  assign res_free = !out_valid_r || out_res.ready;

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.accepted     = out_data_r.accepted;
  assign out_res.removed      = out_data_r.removed;
  assign out_res.evicted_full = out_data_r.evicted_full;

  twdf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  twdf_ctrl #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .age_limit (age_limit_r),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free)
  );

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while previous request in progress");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_free) |=> out_valid_r)
    else $error("finished result not loaded into output register");

  a_evict_implies_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.evicted_full) |-> out_res.accepted)
    else $error("eviction reported without a stored entry");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> !(out_res.accepted && out_res.removed))
    else $error("result reports both stored and removed");

endmodule
`default_nettype wire

[rtl/core/twdf_ram.sv]
`default_nettype none
module twdf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/core/twdf_ctrl.sv]
`default_nettype none
module twdf_ctrl #(
  parameter int unsigned DEPTH     = twdf_pkg::DEPTH_DEFAULT,
  parameter int unsigned KEY_WIDTH = twdf_pkg::KEY_WIDTH_DEFAULT,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned KW = (KEY_WIDTH < twdf_pkg::KEY_PORT_W) ? KEY_WIDTH
                                                                    : twdf_pkg::KEY_PORT_W,
  localparam int unsigned WORD_W = 2 * KW + twdf_pkg::TIME_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  twdf_in_if.sink                              in_req,
  input  wire logic [twdf_pkg::LIMIT_W-1:0]    age_limit,
  output logic                                 mem_we,
  output logic      [AW-1:0]                   mem_waddr,
  output logic      [WORD_W-1:0]               mem_wdata,
  output logic                                 mem_re,
  output logic      [AW-1:0]                   mem_raddr,
  input  wire logic [WORD_W-1:0]               mem_rdata,
  output logic                                 res_valid,
  output twdf_pkg::twdf_result_t               res,
  input  wire logic                            res_free
);

  twdf_pkg::twdf_state_t state_r, state_nxt;

  logic                          act_r, act_nxt;
  logic [twdf_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [KW-1:0]                 stn_r, stn_nxt;
  logic [KW-1:0]                 pay_r, pay_nxt;
  logic [AW-1:0]                 oldest_r, oldest_nxt;
  logic [AW-1:0]                 tail_r, tail_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 addr_r, addr_nxt;
  logic [CW-1:0]                 left_r, left_nxt;
  logic                          pend_r, pend_nxt;
  logic                          seen_r, seen_nxt;
  logic                          rm_r, rm_nxt;

  logic                          accept;
  logic                          full;
  logic                          hit;
  logic [twdf_pkg::TIME_W-1:0]   age;
  logic [AW-1:0]                 oldest_inc;
  logic [AW-1:0]                 tail_inc;
  logic [AW-1:0]                 addr_inc;

  assign accept     = in_req.valid && in_req.ready;
  assign full       = (count_r == CW'(DEPTH));
  assign hit        = (mem_rdata[0 +: KW] == stn_r) && (mem_rdata[KW +: KW] == pay_r);
  assign age        = now_r - mem_rdata[2*KW +: twdf_pkg::TIME_W];
  assign oldest_inc = (oldest_r == AW'(DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign tail_inc   = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign addr_inc   = (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + 1'b1;

  assign res.accepted     = !act_r && !seen_r;
  assign res.removed      = act_r && rm_r;
  assign res.evicted_full = !act_r && !seen_r && full;

  assign mem_waddr = tail_r;
  assign mem_wdata = {now_r, pay_r, stn_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= twdf_pkg::ST_IDLE;
      oldest_r <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    now_r  <= now_nxt;
    stn_r  <= stn_nxt;
    pay_r  <= pay_nxt;
    addr_r <= addr_nxt;
    left_r <= left_nxt;
    seen_r <= seen_nxt;
    rm_r   <= rm_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    now_nxt      = now_r;
    stn_nxt      = stn_r;
    pay_nxt      = pay_r;
    oldest_nxt   = oldest_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    addr_nxt     = addr_r;
    left_nxt     = left_r;
    pend_nxt     = 1'b0;
    seen_nxt     = seen_r;
    rm_nxt       = rm_r;
    in_req.ready = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = addr_r;
    res_valid    = 1'b0;

    unique case (state_r)
      twdf_pkg::ST_IDLE: begin
        in_req.ready = 1'b1;
        mem_raddr    = oldest_r;
        if (accept) begin
          act_nxt  = in_req.action;
          now_nxt  = in_req.now_ms;
          stn_nxt  = in_req.station_key[KW-1:0];
          pay_nxt  = in_req.payload_key[KW-1:0];
          addr_nxt = oldest_r;
          left_nxt = count_r;
          seen_nxt = 1'b0;
          rm_nxt   = 1'b0;
          if (count_r == '0) begin
            state_nxt = twdf_pkg::ST_FINISH;
          end else if (in_req.action) begin
            mem_re    = 1'b1;
            state_nxt = twdf_pkg::ST_AGE;
          end else begin
            state_nxt = twdf_pkg::ST_SCAN;
          end
        end
      end
      twdf_pkg::ST_SCAN: begin
        mem_re   = 1'b1;
        pend_nxt = 1'b1;
        addr_nxt = addr_inc;
        left_nxt = left_r - 1'b1;
        if (pend_r && hit) begin
          seen_nxt = 1'b1;
        end
        if (left_r == CW'(1)) begin
          state_nxt = twdf_pkg::ST_DRAIN;
        end
      end
      twdf_pkg::ST_DRAIN: begin
        if (pend_r && hit) begin
          seen_nxt = 1'b1;
        end
        state_nxt = twdf_pkg::ST_FINISH;
      end
      twdf_pkg::ST_AGE: begin
        rm_nxt    = (age > age_limit);
        state_nxt = twdf_pkg::ST_FINISH;
      end
      twdf_pkg::ST_FINISH: begin
        res_valid = 1'b1;
        if (res_free) begin
          state_nxt = twdf_pkg::ST_IDLE;
          if (res.accepted) begin
            mem_we   = 1'b1;
            tail_nxt = tail_inc;
            if (full) begin
              oldest_nxt = oldest_inc;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end
          if (res.removed) begin
            oldest_nxt = oldest_inc;
            count_nxt  = count_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = twdf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
